[design/dwst_pkg.sv]
// Package for the date wheel spin tracker: widths, limits, codes and the
// structs of the step logic and top level; the interfaces take its widths.
// Depends on nothing.
`default_nettype none

package dwst_pkg;

   localparam int AngleBits = 12;
   localparam int AngleW = AngleBits;
   localparam int DeltaW = AngleBits + 1;
   localparam int FullTurn = 1 << AngleBits;
   localparam int HalfTurn = FullTurn / 2;
   localparam int MonthProdW = AngleBits + 4;

   localparam int CmdW = 1;
   localparam int SampleW = 12;
   localparam int TimeW = 32;
   localparam int MonthW = 4;
   localparam int YearW = 11;
   localparam int OfsW = 5;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 12;
   localparam int OffsetW = 12;

   localparam int MonthsPerYear = 12;
   localparam int YearMin = 2018;
   localparam int YearMax = 2025;
   localparam int YearStart = 2021;
   localparam int OfsMin = 5;
   localparam int OfsMax = 20;
   localparam int OfsStep = 5;
   localparam int SpinMinDelta = 120;
   localparam int SpinMaxDt = 250;
   localparam int SpinMinSpeed = 1600;
   localparam int MsPerSecond = 1000;
   localparam int StepCooldown = 300;
   localparam int MaxSteps = 2;
   localparam int DtW = $clog2(SpinMaxDt + 1);
   localparam int SpeedW = AngleBits + 10;

   localparam logic [OffsetW-1:0] OffsetReset = 12'd2071;

   typedef enum logic [CmdW-1:0] {
      CMD_SAMPLE  = 1'b0,
      CMD_RESTART = 1'b1
   } cmd_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ANGLE_OFFSET  = 1'b0,
      CSR_FUTURE_ENABLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [OffsetW-1:0] angle_offset;
      logic               future_enable;
   } cfg_type;

   typedef struct packed {
      cmd_type            command;
      logic [SampleW-1:0] sample_angle;
      logic [TimeW-1:0]   time_ms;
   } item_type;

   typedef struct packed {
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic              future_active;
      logic [YearW-1:0]  future_year;
      logic              publish;
   } result_type;

   typedef struct packed {
      logic [AngleW-1:0] prev_angle;
      logic [TimeW-1:0]  prev_time;
      logic [MonthW-1:0] prev_month;
      logic              prev_month_valid;
      logic [YearW-1:0]  cur_year;
      logic              in_future;
      logic [OfsW-1:0]   future_offset;
      logic [TimeW-1:0]  last_step_time;
      logic [MonthW-1:0] sent_month;
      logic [YearW-1:0]  sent_year;
      logic              sent_valid;
   } state_type;

endpackage

`default_nettype wire

[design/dwst_if.sv]
// Valid/ready channel interfaces for the date wheel spin tracker: sample
// items in, result items out, and the register write channel.
// Depends on dwst_pkg.
`default_nettype none

interface dwst_req_if import dwst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CmdW-1:0]    command;
   logic [SampleW-1:0] sample_angle;
   logic [TimeW-1:0]   time_ms;

   modport source (output valid, output command, output sample_angle, output time_ms,
                   input ready);
   modport sink (input valid, input command, input sample_angle, input time_ms,
                 output ready);
endinterface

interface dwst_rsp_if import dwst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MonthW-1:0] month;
   logic [YearW-1:0]  year;
   logic              future_active;
   logic [YearW-1:0]  future_year;
   logic              publish;

   modport source (output valid, output month, output year, output future_active,
                   output future_year, output publish, input ready);
   modport sink (input valid, input month, input year, input future_active,
                 input future_year, input publish, output ready);
endinterface

interface dwst_csr_if import dwst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/dwst_step.sv]
// Combinational step logic: from the tracking state, the registers and one
// item it forms the next state and the result item.
// Depends on dwst_pkg.
`default_nettype none

module dwst_step import dwst_pkg::*; (
   input  wire cfg_type    cfg,
   input  wire state_type  state,
   input  wire item_type   item,
   output state_type       next_state,
   output result_type      result
);

   localparam logic signed [DeltaW-1:0] HalfPos = DeltaW'(HalfTurn);
   localparam logic signed [DeltaW-1:0] HalfNeg = -DeltaW'(HalfTurn);
   localparam logic signed [DeltaW-1:0] TurnS = DeltaW'(FullTurn);

   logic [AngleW-1:0]        raw;
   logic [AngleW-1:0]        shifted;
   logic [MonthProdW-1:0]    month_prod;
   logic [MonthW-1:0]        month;
   logic [TimeW-1:0]         dt;
   logic signed [DeltaW-1:0] delta_raw;
   logic signed [DeltaW-1:0] delta;
   logic [AngleW-1:0]        mag;
   logic [SpeedW-1:0]        mag_scaled;
   logic [SpeedW-1:0]        dt_scaled;
   logic                     fast;
   logic                     forward;
   logic [OfsW:0]            step_amt;

   always_comb begin
      raw = AngleW'(item.sample_angle);
      shifted = raw - AngleW'(cfg.angle_offset);
      month_prod = MonthProdW'(shifted) * MonthProdW'(MonthsPerYear);
      month = MonthW'(month_prod[MonthProdW-1:AngleW]) + MonthW'(1);

      dt = item.time_ms - state.prev_time;
      if (dt == '0) begin
         dt = TimeW'(1);
      end

      delta_raw = $signed({1'b0, raw}) - $signed({1'b0, state.prev_angle});
      if (delta_raw > HalfPos) begin
         delta = delta_raw - TurnS;
      end else if (delta_raw < HalfNeg) begin
         delta = delta_raw + TurnS;
      end else begin
         delta = delta_raw;
      end
      mag = delta[DeltaW-1] ? AngleW'(-delta) : AngleW'(delta);
      forward = !delta[DeltaW-1] && (delta != '0);

      mag_scaled = SpeedW'(mag) * SpeedW'(MsPerSecond);
      dt_scaled = SpeedW'(dt[DtW-1:0]) * SpeedW'(SpinMinSpeed);
      fast = (dt <= TimeW'(SpinMaxDt)) && (mag >= AngleW'(SpinMinDelta))
             && (mag_scaled >= dt_scaled);
      step_amt = (mag >= AngleW'(SpinMinDelta * MaxSteps)) ?
                 (OfsW+1)'(OfsStep * MaxSteps) : (OfsW+1)'(OfsStep);
   end

   always_comb begin
      logic          fut_now;
      logic          cool_ok;
      logic [OfsW:0] ofs_sum;
      logic          publish;

      next_state = state;
      publish = 1'b0;
      fut_now = 1'b0;
      cool_ok = 1'b0;
      ofs_sum = '0;

      if (item.command == CMD_RESTART) begin
         next_state.prev_angle = raw;
         next_state.prev_time = item.time_ms;
         next_state.prev_month_valid = 1'b0;
         next_state.prev_month = '0;
         next_state.cur_year = YearW'(YearStart);
         next_state.sent_valid = 1'b0;
         next_state.in_future = 1'b0;
      end else begin
         if (state.prev_month_valid && month != state.prev_month) begin
            if (state.prev_month == MonthW'(MonthsPerYear) && month == MonthW'(1)) begin
               if (state.cur_year < YearW'(YearMax)) begin
                  next_state.cur_year = state.cur_year + YearW'(1);
               end
            end else if (state.prev_month == MonthW'(1)
                         && month == MonthW'(MonthsPerYear)) begin
               if (state.cur_year > YearW'(YearMin)) begin
                  next_state.cur_year = state.cur_year - YearW'(1);
               end
            end
         end
         next_state.prev_month = month;
         next_state.prev_month_valid = 1'b1;

         if (cfg.future_enable && !state.in_future
             && next_state.cur_year >= YearW'(YearMax) && forward && fast) begin
            next_state.in_future = 1'b1;
            next_state.future_offset = OfsW'(OfsMin);
            next_state.last_step_time = item.time_ms;
         end

         fut_now = next_state.in_future;
         cool_ok = (item.time_ms - next_state.last_step_time) >= TimeW'(StepCooldown);

         if (fut_now) begin
            if (fast) begin
               if (forward) begin
                  if (cool_ok) begin
                     next_state.last_step_time = item.time_ms;
                     ofs_sum = (OfsW+1)'(next_state.future_offset) + step_amt;
                     next_state.future_offset = (ofs_sum > (OfsW+1)'(OfsMax)) ?
                                                OfsW'(OfsMax) : OfsW'(ofs_sum);
                  end
               end else if (next_state.future_offset <= OfsW'(OfsMin)) begin
                  next_state.in_future = 1'b0;
               end else if (cool_ok) begin
                  next_state.last_step_time = item.time_ms;
                  if ((OfsW+1)'(next_state.future_offset) < (OfsW+1)'(OfsMin) + step_amt) begin
                     next_state.future_offset = OfsW'(OfsMin);
                  end else begin
                     next_state.future_offset = next_state.future_offset - OfsW'(step_amt);
                  end
               end
            end
         end else if (!state.sent_valid || month != state.sent_month
                      || next_state.cur_year != state.sent_year) begin
            next_state.sent_valid = 1'b1;
            next_state.sent_month = month;
            next_state.sent_year = next_state.cur_year;
            publish = 1'b1;
         end

         next_state.prev_angle = raw;
         next_state.prev_time = item.time_ms;
      end

      result.month = month;
      result.year = next_state.cur_year;
      result.future_active = next_state.in_future;
      result.future_year = YearW'(YearMax) + YearW'(next_state.future_offset);
      result.publish = publish;
   end

endmodule

`default_nettype wire

[design/date_wheel_spin_tracker.sv]
// Date wheel spin tracker. The req channel carries sample items (command,
// raw angle, time in ms); every accepted item gives exactly one result item
// on the rsp channel with month, tracked year, future mode flag, future year
// and a publish flag. The csr channel writes angle_offset (index 0) and
// future_enable (index 1); it is always ready, and the user must write it
// only while idle, which the block does not enforce. An accepted item is
// held in an input register; the step logic then updates the tracking state
// and the result register, which drives rsp. One item is accepted per cycle
// while results are taken; the limit is the single state update per cycle.
// The input register is refilled while a result waits, so the block keeps
// taking items until both registers are full. When the receiver stalls the
// result is held and, once the input register is full too, req ready drops.
// Synchronous reset empties both registers, returns the registers to
// angle_offset 2071 and future_enable 1, and the tracking state to year 2021,
// future offset 5 and no month or publish history.
// Depends on dwst_pkg, the channel interfaces and dwst_step.
`default_nettype none

module date_wheel_spin_tracker import dwst_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   dwst_req_if.sink    req_if,
   dwst_rsp_if.source  rsp_if,
   dwst_csr_if.sink    csr_if
);

   localparam cfg_type CfgReset = '{angle_offset: OffsetReset, future_enable: 1'b1};
   localparam state_type StateReset = '{cur_year: YearW'(YearStart),
                                        future_offset: OfsW'(OfsMin),
                                        default: '0};

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       out_valid_ff, out_valid_in;
   result_type res_ff, res_in;
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   state_type  step_state;
   result_type step_result;
   logic       advance;
   logic       req_take;

   dwst_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .next_state (step_state),
      .result     (step_result)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      item_in = item_ff;
      if (req_take) begin
         item_in.command = cmd_type'(req_if.command);
         item_in.sample_angle = req_if.sample_angle;
         item_in.time_ms = req_if.time_ms;
      end
      out_valid_in = advance || (out_valid_ff && !rsp_if.ready);
      res_in = advance ? step_result : res_ff;
      state_in = advance ? step_state : state_ff;
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_ANGLE_OFFSET:  cfg_in.angle_offset = OffsetW'(csr_if.data);
            CSR_FUTURE_ENABLE: cfg_in.future_enable = csr_if.data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff <= CfgReset;
         state_ff <= StateReset;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff <= cfg_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff <= res_in;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.month = res_ff.month;
   assign rsp_if.year = res_ff.year;
   assign rsp_if.future_active = res_ff.future_active;
   assign rsp_if.future_year = res_ff.future_year;
   assign rsp_if.publish = res_ff.publish;

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (res_ff.year >= YearW'(YearMin) && res_ff.year <= YearW'(YearMax)))
      else $error("tracked year left its range");

   a_offset_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff.future_offset == OfsW'(5) || state_ff.future_offset == OfsW'(10)
      || state_ff.future_offset == OfsW'(15) || state_ff.future_offset == OfsW'(20))
      else $error("future offset is not a valid step");

   a_no_publish_in_future: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.publish) |-> !res_ff.future_active)
      else $error("publish raised in future mode");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.command == CMD_RESTART)
      |=> (!state_ff.in_future && !state_ff.sent_valid && !state_ff.prev_month_valid))
      else $error("restart did not clear tracking");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("waiting item lost or changed");

endmodule

`default_nettype wire

[tb/sv/tb_date_wheel_spin_tracker.sv]
// Self-checking testbench for the date wheel spin tracker: directed rows, then phases of
// random wheel walks under several register settings, each result checked against a row's
// expectation or a behavioural predictor. Depends on dwst_pkg and the channel interfaces.
`timescale 1ns / 1ps

module tb_date_wheel_spin_tracker;
   import dwst_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PhaseCount = 7;
   localparam int ItemsPerPhase = 200;

   typedef struct packed {
      cmd_type            cmd;
      logic [SampleW-1:0] angle;
      logic [TimeW-1:0]   ms;
      logic               typed;
      result_type         want;
   } wheel_row_type;

   typedef enum {SPIN_FWD_FAST, SPIN_FWD_SLOW, SPIN_BWD_FAST, SPIN_BWD_SLOW, SPIN_NOISE}
      spin_style_type;

   logic clock;
   logic reset;

   dwst_req_if req_bus ();
   dwst_rsp_if rsp_bus ();
   dwst_csr_if csr_bus ();

   date_wheel_spin_tracker uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Own copy of the configuration and the tracking state.
   logic [OffsetW-1:0] cfg_offset = OffsetReset;
   bit                 cfg_future_en = 1'b1;
   logic [AngleW-1:0]  last_angle = '0;
   logic [TimeW-1:0]   last_ms = '0;
   logic [MonthW-1:0]  last_month = '0;
   bit                 last_month_known = 1'b0;
   int unsigned        tracked_year = YearStart;
   bit                 future_on = 1'b0;
   int unsigned        future_ofs = OfsMin;
   logic [TimeW-1:0]   last_step_ms = '0;
   logic [MonthW-1:0]  sent_month = '0;
   int unsigned        sent_year = 0;
   bit                 sent_known = 1'b0;

   result_type pending_dates [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  restarts_sent = 0;
   int  future_results = 0;
   int  publish_results = 0;
   int  cycle_count = 0;
   bit  steady = 1'b0;
   bit  long_hold_wanted = 1'b0;

   spin_style_type   walk_kind = SPIN_FWD_FAST;
   int               walk_left = 0;
   logic [AngleW-1:0] walk_angle = '0;
   logic [TimeW-1:0]  walk_ms = '0;

   wheel_row_type directed_rows [25] = '{
      '{CMD_SAMPLE,  12'd2071, 32'd0,     1'b1, '{4'd1, 11'd2021, 1'b0, 11'd2030, 1'b1}},
      '{CMD_SAMPLE,  12'd2071, 32'd0,     1'b1, '{4'd1, 11'd2021, 1'b0, 11'd2030, 1'b0}},
      '{CMD_RESTART, 12'd4095, 32'd100,   1'b1, '{4'd6, 11'd2021, 1'b0, 11'd2030, 1'b0}},
      '{CMD_SAMPLE,  12'd2241, 32'd1000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd193,  32'd2000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd1900, 32'd3000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd2241, 32'd4000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd193,  32'd5000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd1900, 32'd6000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd2241, 32'd7000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd193,  32'd8000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd1900, 32'd9000,  1'b0, '0},
      '{CMD_SAMPLE,  12'd2241, 32'd10000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd193,  32'd11000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd1900, 32'd12000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2241, 32'd13000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd193,  32'd14000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd1900, 32'd15000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2241, 32'd16000, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2481, 32'd16100, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2821, 32'd16300, 1'b0, '0},
      '{CMD_SAMPLE,  12'd3161, 32'd16450, 1'b0, '0},
      '{CMD_SAMPLE,  12'd3611, 32'd16600, 1'b0, '0},
      '{CMD_SAMPLE,  12'd4061, 32'd16760, 1'b0, '0},
      '{CMD_RESTART, 12'd4000, 32'd0,     1'b1, '{4'd6, 11'd2021, 1'b0, 11'd2045, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [MonthW-1:0] month_at(input logic [AngleW-1:0] angle);
      logic [AngleW-1:0] rel;
      int unsigned       rel_i;
      rel = angle - cfg_offset[AngleW-1:0];
      rel_i = rel;
      return MonthW'(rel_i * MonthsPerYear / FullTurn + 1);
   endfunction

   function automatic bit spin_is_fast(input int unsigned mag, input logic [TimeW-1:0] dt);
      longint unsigned lhs;
      longint unsigned rhs;
      if (dt > SpinMaxDt || mag < SpinMinDelta)
         return 1'b0;
      lhs = longint'(mag) * MsPerSecond;
      rhs = longint'(SpinMinSpeed) * longint'(dt);
      return lhs >= rhs;
   endfunction

   function automatic void step_future(input bit forward, input int unsigned steps,
                                       input logic [TimeW-1:0] now);
      logic [TimeW-1:0] since;
      since = now - last_step_ms;
      if (since < StepCooldown)
         return;
      last_step_ms = now;
      if (forward) begin
         future_ofs = future_ofs + OfsStep * steps;
         if (future_ofs > OfsMax)
            future_ofs = OfsMax;
      end else if (future_ofs < OfsMin + OfsStep * steps) begin
         future_ofs = OfsMin;
      end else begin
         future_ofs = future_ofs - OfsStep * steps;
      end
   endfunction

   function automatic result_type track_wheel(input item_type it);
      result_type        r;
      logic [MonthW-1:0] mon;
      logic [TimeW-1:0]  dt;
      int                delta;
      int unsigned       mag;
      int unsigned       steps;
      bit                fast;
      bit                pub;
      mon = month_at(it.sample_angle);
      pub = 1'b0;
      if (it.command == CMD_RESTART) begin
         last_angle = it.sample_angle;
         last_ms = it.time_ms;
         last_month_known = 1'b0;
         last_month = '0;
         tracked_year = YearStart;
         sent_known = 1'b0;
         future_on = 1'b0;
      end else begin
         dt = it.time_ms - last_ms;
         if (dt == 0)
            dt = 1;
         delta = int'(it.sample_angle) - int'(last_angle);
         if (delta > HalfTurn)
            delta -= FullTurn;
         else if (delta < -HalfTurn)
            delta += FullTurn;
         mag = (delta < 0) ? -delta : delta;
         if (last_month_known && mon != last_month) begin
            if (last_month == MonthsPerYear && mon == 1) begin
               if (tracked_year < YearMax)
                  tracked_year++;
            end else if (last_month == 1 && mon == MonthsPerYear) begin
               if (tracked_year > YearMin)
                  tracked_year--;
            end
         end
         last_month = mon;
         last_month_known = 1'b1;
         fast = spin_is_fast(mag, dt);
         if (cfg_future_en && !future_on && tracked_year >= YearMax && delta > 0 && fast) begin
            future_on = 1'b1;
            future_ofs = OfsMin;
            last_step_ms = it.time_ms;
         end
         if (future_on) begin
            if (fast) begin
               steps = mag / SpinMinDelta;
               if (steps > MaxSteps)
                  steps = MaxSteps;
               if (delta > 0)
                  step_future(1'b1, steps, it.time_ms);
               else if (future_ofs <= OfsMin)
                  future_on = 1'b0;
               else
                  step_future(1'b0, steps, it.time_ms);
            end
         end else if (!sent_known || mon != sent_month || tracked_year != sent_year) begin
            sent_known = 1'b1;
            sent_month = mon;
            sent_year = tracked_year;
            pub = 1'b1;
         end
         last_angle = it.sample_angle;
         last_ms = it.time_ms;
      end
      r.month = mon;
      r.year = YearW'(tracked_year);
      r.future_active = future_on;
      r.future_year = YearW'(YearMax + future_ofs);
      r.publish = pub;
      return r;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_item(input item_type it, input int gap, input bit typed,
                            input result_type want);
      result_type guess;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= it.command;
      req_bus.sample_angle <= it.sample_angle;
      req_bus.time_ms <= it.time_ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      guess = track_wheel(it);
      pending_dates.push_back(typed ? want : guess);
      items_sent++;
      if (it.command == CMD_RESTART)
         restarts_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_ANGLE_OFFSET)
         cfg_offset = value[OffsetW-1:0];
      else
         cfg_future_en = value[0];
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Random wheel walk: segments of forward or backward turning at slow or
   // spinning speed, with the odd stretch of noise and the odd restart.
   task automatic next_wheel_item(output item_type it);
      int unsigned r;
      int unsigned mag;
      int unsigned lim;
      if (walk_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 35)
            walk_kind = SPIN_FWD_FAST;
         else if (r < 62)
            walk_kind = SPIN_FWD_SLOW;
         else if (r < 80)
            walk_kind = SPIN_BWD_FAST;
         else if (r < 90)
            walk_kind = SPIN_BWD_SLOW;
         else
            walk_kind = SPIN_NOISE;
         walk_left = $urandom_range(4, 40);
         if ($urandom_range(0, 7) == 0)
            walk_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      end
      walk_left--;
      it.command = CMD_SAMPLE;
      if ($urandom_range(0, 149) == 0) begin
         it.command = CMD_RESTART;
         walk_angle = AngleW'($urandom_range(0, FullTurn - 1));
         if ($urandom_range(0, 3) == 0)
            walk_ms = $urandom;
         else
            walk_ms = walk_ms + $urandom_range(0, 5000);
      end else begin
         case (walk_kind)
            SPIN_FWD_FAST, SPIN_BWD_FAST: begin
               if ($urandom_range(0, 9) == 0)
                  mag = $urandom_range(0, HalfTurn);
               else
                  mag = $urandom_range(SpinMinDelta - 8, 340);
               lim = mag * MsPerSecond / SpinMinSpeed;
               if (lim > SpinMaxDt)
                  lim = SpinMaxDt;
               walk_ms = walk_ms + $urandom_range(0, lim + 3);
               if (walk_kind == SPIN_FWD_FAST)
                  walk_angle = walk_angle + AngleW'(mag);
               else
                  walk_angle = walk_angle - AngleW'(mag);
            end
            SPIN_FWD_SLOW, SPIN_BWD_SLOW: begin
               mag = $urandom_range(1, 340);
               walk_ms = walk_ms + $urandom_range(100, 1500);
               if (walk_kind == SPIN_FWD_SLOW)
                  walk_angle = walk_angle + AngleW'(mag);
               else
                  walk_angle = walk_angle - AngleW'(mag);
            end
            default: begin
               walk_angle = AngleW'($urandom_range(0, FullTurn - 1));
               walk_ms = $urandom;
            end
         endcase
      end
      it.sample_angle = walk_angle;
      it.time_ms = walk_ms;
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_dates.size() == 0) begin
            $error("result item arrived with no expectation pending");
            mismatches++;
         end else begin
            want = pending_dates.pop_front();
            check_field("month", want.month, rsp_bus.month);
            check_field("year", want.year, rsp_bus.year);
            check_field("future_active", want.future_active, rsp_bus.future_active);
            check_field("future_year", want.future_year, rsp_bus.future_year);
            check_field("publish", want.publish, rsp_bus.publish);
            if (rsp_bus.future_active)
               future_results++;
            if (rsp_bus.publish)
               publish_results++;
         end
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 2) begin
            hold_left = $urandom_range(8, 40);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      item_type           it;
      logic [OffsetW-1:0] ofs;
      bit                 en;
      int                 i;
      int                 phase;
      int                 n;
      int                 burst_left;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_SAMPLE;
      req_bus.sample_angle = '0;
      req_bus.time_ms = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ANGLE_OFFSET;
      csr_bus.data = '0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_ANGLE_OFFSET, OffsetReset);
      write_csr(CSR_FUTURE_ENABLE, CsrDataW'(1'b1));
      for (i = 0; i < $size(directed_rows); i++) begin
         it.command = directed_rows[i].cmd;
         it.sample_angle = directed_rows[i].angle;
         it.time_ms = directed_rows[i].ms;
         send_item(it, pick_gap(), directed_rows[i].typed, directed_rows[i].want);
      end

      for (phase = 0; phase < PhaseCount; phase++) begin
         release_req();
         drain_results();
         repeat (4) @(negedge clock);
         case (phase)
            0: begin ofs = '0;                  en = 1'b1; end
            1: begin ofs = '1;                  en = 1'b1; end
            2: begin ofs = OffsetW'($urandom);  en = 1'b0; end
            3: begin ofs = OffsetReset;         en = 1'b1; end
            4: begin ofs = OffsetW'($urandom);  en = bit'($urandom_range(0, 1)); end
            5: begin ofs = 12'd1;               en = 1'b1; end
            default: begin ofs = 12'd2048;      en = 1'b0; end
         endcase
         write_csr(CSR_ANGLE_OFFSET, ofs);
         write_csr(CSR_FUTURE_ENABLE, CsrDataW'(en));
         steady = (phase == 3);
         for (n = 0; n < ItemsPerPhase; n++) begin
            // Hold the receiver off while items keep coming, so the block
            // fills and stalls its input; then let every result drain.
            if (phase == 1 && n == 40) begin
               long_hold_wanted = 1'b1;
               burst_left = 30;
            end
            next_wheel_item(it);
            send_item(it, (burst_left > 0) ? 0 : pick_gap(), 1'b0, '0);
            if (burst_left > 0) begin
               burst_left--;
               if (burst_left == 0) begin
                  release_req();
                  drain_results();
               end
            end
         end
      end

      release_req();
      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d items (%0d restarts) under %0d register settings.",
               items_sent, restarts_sent, PhaseCount + 1);
      $display("Results seen in future mode: %0d, with publish raised: %0d.",
               future_results, publish_results);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
